### design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers shared by the rtl, empty bodies for synthesis
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// plain property checked on every rising edge outside reset
`define RTVJ_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// same-cycle implication checked outside reset
`define RTVJ_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`else

`define RTVJ_ASSERT(label, clk, rst_n, prop, msg)
`define RTVJ_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)

`endif

`endif

### design/rtvj_pkg.sv
// ----------------------------------------------------------------------------
// rtvj_pkg
// types, codes and constants of the trapezoid velocity joint
// ----------------------------------------------------------------------------
package rtvj_pkg;

    localparam int TICK_BITS = 16;
    localparam int POS_BITS  = 32;

    localparam logic [TICK_BITS-1:0] TICK_MAX = '1;

    // 0.02 rad in q16.16, rounded to nearest
    localparam logic signed [POS_BITS:0] POS_TOL     = (POS_BITS+1)'(1311);
    localparam logic signed [POS_BITS:0] POS_TOL_NEG = -POS_TOL;

    // beat kinds
    localparam logic [1:0] KIND_START = 2'd0;
    localparam logic [1:0] KIND_TICK  = 2'd1;
    localparam logic [1:0] KIND_ABORT = 2'd2;

    // joint status codes
    localparam logic [2:0] ST_MOVING  = 3'd0;
    localparam logic [2:0] ST_STATIC  = 3'd1;
    localparam logic [2:0] ST_REACHED = 3'd2;
    localparam logic [2:0] ST_FORCE   = 3'd3;
    localparam logic [2:0] ST_ENDED   = 3'd4;
    localparam logic [2:0] ST_ABORTED = 3'd5;

    // register indexes
    localparam logic [2:0] REG_CRUISE_VEL   = 3'd0;
    localparam logic [2:0] REG_ACCEL_STEP   = 3'd1;
    localparam logic [2:0] REG_DECEL_STEP   = 3'd2;
    localparam logic [2:0] REG_ACCEL_TICKS  = 3'd3;
    localparam logic [2:0] REG_CRUISE_TICKS = 3'd4;
    localparam logic [2:0] REG_DECEL_TICKS  = 3'd5;
    localparam logic [2:0] REG_JOINT_MODE   = 3'd6;

    localparam int MODE_STATIC = 0;
    localparam int MODE_PAD    = 1;

    typedef struct packed {
        logic signed [31:0] cruise_velocity;
        logic [30:0]        accel_step;
        logic [30:0]        decel_step;
        logic [15:0]        accel_ticks;
        logic [15:0]        cruise_ticks;
        logic [15:0]        decel_ticks;
        logic [1:0]         joint_mode;
    } cfg_t;

    typedef struct packed {
        logic [1:0]                 kind;
        logic signed [POS_BITS-1:0] target_position;
        logic [14:0]                force_limit;
        logic signed [POS_BITS-1:0] actual_position;
        logic [14:0]                contact_force;
    } item_t;

    typedef struct packed {
        logic signed [31:0]   velocity_command;
        logic [2:0]           joint_status;
        logic [TICK_BITS-1:0] tick_index;
        logic [TICK_BITS-1:0] stop_tick;
        logic                 stop_tick_valid;
        logic                 move_done;
    } result_t;

    typedef struct packed {
        logic [31:0]                profile_speed;
        logic [TICK_BITS-1:0]       tick_count;
        logic [TICK_BITS-1:0]       first_stop_tick;
        logic                       stop_recorded;
        logic signed [POS_BITS-1:0] latched_target;
        logic [14:0]                latched_force_limit;
        logic                       move_active;
    } state_t;

endpackage

### design/rtvj_cfg.sv
// ----------------------------------------------------------------------------
// rtvj_cfg
// apb register file for the profile and joint mode settings
// ----------------------------------------------------------------------------
module rtvj_cfg
    import rtvj_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    cfg_t       cfg_reg;
    logic [2:0] reg_idx;
    logic       wr_en;

    assign reg_idx = paddr[4:2];
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_CRUISE_VEL:   cfg_reg.cruise_velocity <= $signed(pwdata);
                REG_ACCEL_STEP:   cfg_reg.accel_step      <= pwdata[30:0];
                REG_DECEL_STEP:   cfg_reg.decel_step      <= pwdata[30:0];
                REG_ACCEL_TICKS:  cfg_reg.accel_ticks     <= pwdata[15:0];
                REG_CRUISE_TICKS: cfg_reg.cruise_ticks    <= pwdata[15:0];
                REG_DECEL_TICKS:  cfg_reg.decel_ticks     <= pwdata[15:0];
                REG_JOINT_MODE:   cfg_reg.joint_mode      <= pwdata[1:0];
                default:          cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_CRUISE_VEL:   prdata = $unsigned(cfg_reg.cruise_velocity);
            REG_ACCEL_STEP:   prdata = {1'b0, cfg_reg.accel_step};
            REG_DECEL_STEP:   prdata = {1'b0, cfg_reg.decel_step};
            REG_ACCEL_TICKS:  prdata = {16'd0, cfg_reg.accel_ticks};
            REG_CRUISE_TICKS: prdata = {16'd0, cfg_reg.cruise_ticks};
            REG_DECEL_TICKS:  prdata = {16'd0, cfg_reg.decel_ticks};
            REG_JOINT_MODE:   prdata = {30'd0, cfg_reg.joint_mode};
            default:          prdata = 32'd0;
        endcase
    end

endmodule

### design/rtvj_step.sv
// ----------------------------------------------------------------------------
// rtvj_step
// one beat of the profile: next joint state and the result beat
// ----------------------------------------------------------------------------
module rtvj_step
    import rtvj_pkg::*;
(
    input  cfg_t    cfg,
    input  state_t  state,
    input  item_t   item,
    output state_t  state_next,
    output result_t res
);

    logic [17:0]         prof_len;
    logic [16:0]         cruise_end;
    logic [16:0]         idx;
    logic                neg;
    logic [31:0]         cmag;
    logic [32:0]         accel_sum;
    logic [31:0]         speed;
    logic signed [POS_BITS:0] diff;
    logic                in_tol;
    logic                at_force;
    logic                ended;

    always_comb
    begin
        prof_len   = {2'b0, cfg.accel_ticks} + {2'b0, cfg.cruise_ticks}
                   + {2'b0, cfg.decel_ticks};
        cruise_end = {1'b0, cfg.accel_ticks} + {1'b0, cfg.cruise_ticks};
        idx        = {1'b0, state.tick_count} + 17'd1;
        neg        = cfg.cruise_velocity[31];
        cmag       = neg ? (32'd0 - $unsigned(cfg.cruise_velocity))
                         : $unsigned(cfg.cruise_velocity);
        accel_sum  = {1'b0, state.profile_speed} + {2'b0, cfg.accel_step};

        // ramp up, cruise, ramp down, zero past the end
        if ({1'b0, idx} >= prof_len)
            speed = 32'd0;
        else if (idx < {1'b0, cfg.accel_ticks})
            speed = (accel_sum > {1'b0, cmag}) ? cmag : accel_sum[31:0];
        else if (idx <= cruise_end)
            speed = cmag;
        else if (state.profile_speed > {1'b0, cfg.decel_step})
            speed = state.profile_speed - {1'b0, cfg.decel_step};
        else
            speed = 32'd0;

        diff = $signed({item.actual_position[POS_BITS-1], item.actual_position})
             - $signed({state.latched_target[POS_BITS-1], state.latched_target});
        in_tol   = (diff < POS_TOL) && (diff > POS_TOL_NEG);
        at_force = cfg.joint_mode[MODE_PAD] &&
                   (item.contact_force >= state.latched_force_limit);
        ended    = ({2'b0, state.tick_count} >= prof_len) ||
                   (state.tick_count == TICK_MAX);

        state_next = state;
        res.velocity_command = 32'sd0;
        res.joint_status     = ST_MOVING;
        res.move_done        = 1'b0;

        case (item.kind)
            KIND_START:
            begin
                state_next.latched_target      = item.target_position;
                state_next.latched_force_limit = item.force_limit;
                state_next.profile_speed       = 32'd0;
                state_next.tick_count          = '0;
                state_next.first_stop_tick     = '0;
                state_next.stop_recorded       = 1'b0;
                state_next.move_active         = 1'b1;
            end
            KIND_ABORT:
            begin
                state_next.move_active = 1'b0;
                res.joint_status       = ST_ABORTED;
                res.move_done          = state.move_active;
            end
            KIND_TICK:
            begin
                if (!state.move_active)
                begin
                    res.joint_status = ST_ENDED;
                end
                else if (ended)
                begin
                    if (!state.stop_recorded)
                    begin
                        state_next.first_stop_tick = state.tick_count;
                        state_next.stop_recorded   = 1'b1;
                    end
                    state_next.move_active = 1'b0;
                    res.joint_status       = ST_ENDED;
                    res.move_done          = 1'b1;
                end
                else
                begin
                    state_next.tick_count    = idx[TICK_BITS-1:0];
                    state_next.profile_speed = speed;
                    if (cfg.joint_mode[MODE_STATIC])
                    begin
                        res.joint_status = ST_STATIC;
                    end
                    else if (in_tol || at_force)
                    begin
                        if (!state.stop_recorded)
                        begin
                            state_next.first_stop_tick = state.tick_count;
                            state_next.stop_recorded   = 1'b1;
                        end
                        res.joint_status = in_tol ? ST_REACHED : ST_FORCE;
                    end
                    else
                    begin
                        res.velocity_command = neg ? $signed(32'd0 - speed) : $signed(speed);
                    end
                end
            end
            default:
            begin
                res.joint_status = state.move_active ? ST_MOVING : ST_ENDED;
            end
        endcase

        res.tick_index      = state_next.tick_count;
        res.stop_tick       = state_next.first_stop_tick;
        res.stop_tick_valid = state_next.stop_recorded;
    end

endmodule

### design/reactive_trapezoid_velocity_joint.sv
// ----------------------------------------------------------------------------
// reactive_trapezoid_velocity_joint
// per-tick trapezoid velocity generator for one joint with stop detection
// ----------------------------------------------------------------------------
//
//  channel  role    payload
//  -------  ------  ---------------------------------------------------------
//  s_*      in      one command beat: start, tick or abort
//  m_*      out     one result beat per command beat, tlast marks move end
//  apb      config  seven profile and mode registers at 4*index
//
//  one beat enters per cycle while s_tready is high, and its result leaves
//  through the input register, one pass of step logic and the result register
//  the step logic reads and writes the joint state in the same cycle, so
//  back-to-back beats each see the state left by the previous one
//  a stalled output holds the result register and backs up into the input
//  register; s_tready falls only when both are full
//  reset clears the profile registers, joint state and both valid flags
//
module reactive_trapezoid_velocity_joint
    import rtvj_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    // target_position[31:0] force_limit[46:32] actual_position[78:47]
    // contact_force[93:79], zero fill [95:94]
    input  logic [95:0] s_tdata,
    // kind[1:0]
    input  logic [1:0]  s_tuser,

    output logic        m_tvalid,
    input  logic        m_tready,
    // velocity_command[31:0] joint_status[34:32] tick_index[50:35]
    // stop_tick[66:51] stop_tick_valid[67], zero fill [71:68]
    output logic [71:0] m_tdata,
    // move_done
    output logic        m_tlast,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

`include "assert_macros.svh"

    cfg_t    cfg;
    item_t   in_item_reg;
    logic    in_valid_reg;
    state_t  state_reg;
    state_t  state_next;
    result_t res_next;
    result_t out_res_reg;
    logic    out_valid_reg;
    logic    out_free;
    logic    advance;
    logic    in_take;

    // register file
    rtvj_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // handshake: the result register frees itself when taken this cycle
    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;
    assign in_take  = s_tvalid && s_tready;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_item_reg.kind            <= s_tuser;
            in_item_reg.target_position <= $signed(s_tdata[31:0]);
            in_item_reg.force_limit     <= s_tdata[46:32];
            in_item_reg.actual_position <= $signed(s_tdata[78:47]);
            in_item_reg.contact_force   <= s_tdata[93:79];
        end
    end

    // one pass of profile logic
    rtvj_step u_step (
        .cfg        (cfg),
        .state      (state_reg),
        .item       (in_item_reg),
        .state_next (state_next),
        .res        (res_next)
    );

    // joint state moves only when a beat passes into the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_res_reg <= res_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_res_reg.move_done;
    assign m_tdata  = {4'd0,
                       out_res_reg.stop_tick_valid,
                       out_res_reg.stop_tick,
                       out_res_reg.tick_index,
                       out_res_reg.joint_status,
                       out_res_reg.velocity_command};

    // a held joint never commands motion
    `RTVJ_ASSERT_IMP(a_zero_when_held, clk, rst_n, m_tvalid && (out_res_reg.joint_status != ST_MOVING), out_res_reg.velocity_command == 32'sd0, "nonzero velocity while joint is held")

    // a move ends only through profile end or abort
    `RTVJ_ASSERT_IMP(a_done_status, clk, rst_n, m_tvalid && m_tlast, (out_res_reg.joint_status == ST_ENDED) || (out_res_reg.joint_status == ST_ABORTED), "move done with wrong status")

    // no recorded stop means the stop tick reads zero
    `RTVJ_ASSERT_IMP(a_stop_clear, clk, rst_n, m_tvalid && !out_res_reg.stop_tick_valid, out_res_reg.stop_tick == '0, "stop tick set without a recorded stop")

    // both stages full and output stalled must stall the input
    `RTVJ_ASSERT_IMP(a_backpressure, clk, rst_n, in_valid_reg && out_valid_reg && !m_tready, !s_tready, "input taken while pipeline is full")

endmodule

### bench/reactive_trapezoid_velocity_joint_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// reactive_trapezoid_velocity_joint_test
// self-checking bench for the per-tick trapezoid velocity joint
// ----------------------------------------------------------------------------
//
//  every command beat taken on s_* runs through a predictor of the joint that
//  keeps its own copy of the profile registers and the joint state; the
//  predicted result is queued and each m_* beat is compared against the oldest
//  entry, field by field
//
//  the run is a chain of tests: profile shape, stop and abort handling, pad and
//  static modes, full-scale registers, then a long stretch of random moves
//  over a series of random profiles
//
//  registers are only rewritten when no result is outstanding; the sender and
//  the receiver both idle at random, one phase holds the receiver off long
//  enough to back the block up, and a watchdog ends the run if nothing moves
//
module reactive_trapezoid_velocity_joint_test;
    import rtvj_pkg::*;

    localparam int HALF_PERIOD      = 5;
    localparam int RESET_CYCLES     = 5;
    localparam int WATCHDOG_LIMIT   = 5000;
    localparam int HOLD_CYCLES      = 100;
    localparam int SETTLE_CYCLES    = 4;
    localparam int RANDOM_BEATS     = 1500;
    localparam int PHASE_BEATS      = 200;
    localparam int REPORT_LIMIT     = 10;
    localparam int FULL_SCALE_TICKS = 40;
    // 0.02 rad in q16.16
    localparam longint TOLERANCE  = 1311;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;

    logic        s_tvalid = 1'b0;
    logic        s_tready;
    // target_position[31:0] force_limit[46:32] actual_position[78:47]
    // contact_force[93:79], zero fill [95:94]
    logic [95:0] s_tdata  = '0;
    // kind[1:0]
    logic [1:0]  s_tuser  = KIND_TICK;

    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // velocity_command[31:0] joint_status[34:32] tick_index[50:35]
    // stop_tick[66:51] stop_tick_valid[67], zero fill [71:68]
    logic [71:0] m_tdata;
    // move_done
    logic        m_tlast;

    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [4:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    // predictor copy of the profile registers
    cfg_t               joint_cfg = '0;

    // predictor copy of the joint state
    logic [32:0]        ramp_speed    = '0;
    logic [15:0]        ticks_done    = '0;
    logic [15:0]        stop_at       = '0;
    logic               stop_seen     = 1'b0;
    logic signed [31:0] goal_position = '0;
    logic [14:0]        force_cap     = '0;
    logic               moving        = 1'b0;

    result_t expected_results[$];

    int  error_count  = 0;
    int  stall_cycles = 0;
    int  beats_sent   = 0;
    // quiet turns off idling on both sides
    bit  quiet        = 1'b0;
    // hold_req asks the receiver for one long hold-off, it clears it itself
    bit  hold_req     = 1'b0;

    reactive_trapezoid_velocity_joint dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #HALF_PERIOD clk = ~clk;

    // ------------------------------------------------------------------------
    // joint predictor
    // ------------------------------------------------------------------------

    // keeps the first stop only
    function automatic void note_stop(logic [15:0] at_tick);
        if (!stop_seen)
        begin
            stop_at   = at_tick;
            stop_seen = 1'b1;
        end
    endfunction

    function automatic result_t predict_joint_step(item_t it);
        result_t     r;
        int unsigned span;
        int unsigned idx;
        logic        neg;
        logic [32:0] cruise_mag;
        logic [32:0] speed;
        logic [15:0] elapsed;
        longint      offset;

        r    = '0;
        span = 32'(joint_cfg.accel_ticks) + 32'(joint_cfg.cruise_ticks)
             + 32'(joint_cfg.decel_ticks);
        neg  = joint_cfg.cruise_velocity[31];
        // magnitude of the cruise velocity, 2^31 fits in 33 bits
        cruise_mag = neg ? 33'd0 - {1'b1, joint_cfg.cruise_velocity}
                         : {1'b0, joint_cfg.cruise_velocity};

        case (it.kind)
            KIND_START:
            begin
                goal_position = it.target_position;
                force_cap     = it.force_limit;
                ramp_speed    = '0;
                ticks_done    = '0;
                stop_at       = '0;
                stop_seen     = 1'b0;
                moving        = 1'b1;
                r.joint_status = ST_MOVING;
            end
            KIND_ABORT:
            begin
                r.move_done    = moving;
                moving         = 1'b0;
                r.joint_status = ST_ABORTED;
            end
            KIND_TICK:
            begin
                if (!moving)
                    r.joint_status = ST_ENDED;
                else if (32'(ticks_done) >= span || ticks_done == TICK_MAX)
                begin
                    // profile ran out or the counter is pinned
                    note_stop(ticks_done);
                    moving         = 1'b0;
                    r.joint_status = ST_ENDED;
                    r.move_done    = 1'b1;
                end
                else
                begin
                    elapsed    = ticks_done;
                    ticks_done = ticks_done + 16'd1;
                    idx        = 32'(ticks_done);
                    if (idx >= span)
                        speed = '0;
                    else if (idx < 32'(joint_cfg.accel_ticks))
                    begin
                        speed = ramp_speed + 33'(joint_cfg.accel_step);
                        if (speed > cruise_mag)
                            speed = cruise_mag;
                    end
                    else if (idx <= 32'(joint_cfg.accel_ticks)
                                    + 32'(joint_cfg.cruise_ticks))
                        speed = cruise_mag;
                    else if (ramp_speed > 33'(joint_cfg.decel_step))
                        speed = ramp_speed - 33'(joint_cfg.decel_step);
                    else
                        speed = '0;
                    // the ramp keeps running while the joint is held
                    ramp_speed = speed;

                    offset = longint'($signed(it.actual_position))
                           - longint'($signed(goal_position));
                    if (joint_cfg.joint_mode[MODE_STATIC])
                        r.joint_status = ST_STATIC;
                    else if (offset < TOLERANCE && offset > -TOLERANCE)
                    begin
                        note_stop(elapsed);
                        r.joint_status = ST_REACHED;
                    end
                    else if (joint_cfg.joint_mode[MODE_PAD]
                             && it.contact_force >= force_cap)
                    begin
                        note_stop(elapsed);
                        r.joint_status = ST_FORCE;
                    end
                    else
                    begin
                        r.joint_status     = ST_MOVING;
                        r.velocity_command = neg ? 32'(33'd0 - speed) : speed[31:0];
                    end
                end
            end
            default:
                // unused kind leaves the state alone
                r.joint_status = moving ? ST_MOVING : ST_ENDED;
        endcase

        r.tick_index      = ticks_done;
        r.stop_tick       = stop_at;
        r.stop_tick_valid = stop_seen;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // shared drivers, all called right after a rising edge
    // ------------------------------------------------------------------------

    function automatic item_t make_item(logic [1:0] kind, logic [31:0] target,
                                        logic [14:0] limit, logic [31:0] actual,
                                        logic [14:0] contact);
        item_t it;
        it.kind            = kind;
        it.target_position = target;
        it.force_limit     = limit;
        it.actual_position = actual;
        it.contact_force   = contact;
        return it;
    endfunction

    // mostly back to back or short gaps, now and then a long one
    function automatic int pick_idle_cycles();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    // setup cycle then access cycle, the register takes it on the access edge
    task automatic write_register(logic [2:0] index, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (index)
            REG_CRUISE_VEL:   joint_cfg.cruise_velocity = value;
            REG_ACCEL_STEP:   joint_cfg.accel_step      = value[30:0];
            REG_DECEL_STEP:   joint_cfg.decel_step      = value[30:0];
            REG_ACCEL_TICKS:  joint_cfg.accel_ticks     = value[15:0];
            REG_CRUISE_TICKS: joint_cfg.cruise_ticks    = value[15:0];
            REG_DECEL_TICKS:  joint_cfg.decel_ticks     = value[15:0];
            REG_JOINT_MODE:   joint_cfg.joint_mode      = value[1:0];
            default: ;
        endcase
        // the bus idles between accesses
        @(posedge clk);
    endtask

    // offers one beat until it is taken, predicts it, then maybe idles;
    // tvalid stays up when the next beat follows at once
    task automatic send_beat(item_t it);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= it.kind;
        s_tdata  <= {2'b00, it.contact_force, it.actual_position,
                     it.force_limit, it.target_position};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        expected_results.insert(expected_results.size(), predict_joint_step(it));
        beats_sent++;
        gap = pick_idle_cycles();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // sender pauses until every result is back and the pipe is empty
    task automatic wait_until_drained();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic load_profile(logic [31:0] cruise, logic [31:0] up_step,
                                logic [31:0] down_step, logic [31:0] up_ticks,
                                logic [31:0] hold_ticks, logic [31:0] down_ticks,
                                logic [31:0] mode);
        write_register(REG_CRUISE_VEL,   cruise);
        write_register(REG_ACCEL_STEP,   up_step);
        write_register(REG_DECEL_STEP,   down_step);
        write_register(REG_ACCEL_TICKS,  up_ticks);
        write_register(REG_CRUISE_TICKS, hold_ticks);
        write_register(REG_DECEL_TICKS,  down_ticks);
        write_register(REG_JOINT_MODE,   mode);
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // ramp up into the cruise cap, hold, ramp down past zero, run off the end
    task automatic test_profile_shape();
        int k;
        load_profile(32'h0003_0000, 32'h0002_0000, 32'h0002_0000,
                     32'd3, 32'd1, 32'd3, 32'd0);
        send_beat(make_item(KIND_START, 32'd0, 15'd0, 32'd0, 15'd0));
        for (k = 0; k < 8; k++)
            send_beat(make_item(KIND_TICK, 32'd0, 15'd0, 32'h7fff_ffff, 15'd0));
        // idle tick after the move has ended
        send_beat(make_item(KIND_TICK, 32'd0, 15'd0, 32'h7fff_ffff, 15'd0));
    endtask

    // tolerance edges at the most negative target, repeated stop, aborts
    task automatic test_stop_and_abort();
        send_beat(make_item(KIND_START, 32'h8000_0000, 15'h7fff, 32'd0, 15'd0));
        send_beat(make_item(KIND_TICK, 32'd0, 15'd0, 32'h7fff_ffff, 15'h7fff));
        // one lsb outside tolerance
        send_beat(make_item(KIND_TICK, 32'd0, 15'd0, 32'h8000_051f, 15'd0));
        // just inside tolerance, first stop gets recorded
        send_beat(make_item(KIND_TICK, 32'd0, 15'd0, 32'h8000_051e, 15'd0));
        // wraps in 32 bits but the exact difference is huge
        send_beat(make_item(KIND_TICK, 32'd0, 15'd0, 32'h7fff_fae2, 15'd0));
        send_beat(make_item(KIND_TICK, 32'd0, 15'd0, 32'h8000_0000, 15'd0));
        send_beat(make_item(KIND_ABORT, 32'd0, 15'd0, 32'd0, 15'd0));
        // abort with nothing active is not a move end
        send_beat(make_item(KIND_ABORT, 32'd0, 15'd0, 32'd0, 15'd0));
        send_beat(make_item(2'd3, 32'hffff_ffff, 15'h7fff, 32'hffff_ffff, 15'h7fff));
    endtask

    // negative cruise with a pad, then a static joint restarted mid-move
    task automatic test_pad_and_static();
        wait_until_drained();
        write_register(REG_CRUISE_VEL, 32'hfffd_0000);
        write_register(REG_JOINT_MODE, 32'd2);
        send_beat(make_item(KIND_START, 32'd0, 15'h7fff, 32'd0, 15'd0));
        send_beat(make_item(KIND_TICK, 32'd0, 15'd0, 32'h0001_0000, 15'h7ffe));
        send_beat(make_item(KIND_TICK, 32'd0, 15'd0, 32'h0001_0000, 15'h7fff));
        send_beat(make_item(2'd3, 32'd0, 15'd0, 32'd0, 15'd0));
        wait_until_drained();
        write_register(REG_JOINT_MODE, 32'd3);
        send_beat(make_item(KIND_START, 32'd0, 15'd0, 32'd0, 15'd0));
        send_beat(make_item(KIND_TICK, 32'd0, 15'd0, 32'd0, 15'h7fff));
    endtask

    // full-scale steps and tick counts with the most negative cruise velocity
    task automatic test_full_scale();
        int k;
        wait_until_drained();
        quiet = 1'b1;
        load_profile(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
                     32'h0000_ffff, 32'h0000_ffff, 32'h0000_ffff, 32'd0);
        send_beat(make_item(KIND_START, 32'd0, 15'd0, 32'd0, 15'd0));
        for (k = 0; k < FULL_SCALE_TICKS; k++)
            send_beat(make_item(KIND_TICK, 32'd0, 15'd0, 32'h4000_0000, 15'd0));
        wait_until_drained();
        quiet = 1'b0;
    endtask

    function automatic logic [31:0] pick_ticks();
        int r;
        r = $urandom_range(0, 99);
        // upper bits are junk the register must drop
        if (r < 10)
            return {16'($urandom_range(0, 65535)), 16'd0};
        else if (r < 95)
            return {16'($urandom), 16'($urandom_range(1, 6))};
        else
            return {16'($urandom), 16'($urandom_range(20, 60))};
    endfunction

    function automatic logic [31:0] pick_step();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return 32'd0;
        else if (r < 20)
            return 32'h7fff_ffff;
        else if (r < 60)
            return $urandom_range(0, 32'h0002_0000);
        else
            return $urandom;
    endfunction

    function automatic logic [31:0] pick_cruise();
        int r;
        r = $urandom_range(0, 99);
        if (r < 12)
            return 32'h8000_0000;
        else if (r < 25)
            return 32'h7fff_ffff;
        else if (r < 50)
            return 32'($urandom_range(0, 32'h0008_0000)) * ($urandom_range(0, 1) ? 1 : -1);
        else
            return $urandom;
    endfunction

    task automatic load_random_profile();
        logic [31:0] mode;
        mode = {30'($urandom), 2'b00} | 32'($urandom_range(0, 3));
        load_profile(pick_cruise(), pick_step(), pick_step(),
                     pick_ticks(), pick_ticks(), pick_ticks(), mode);
    endtask

    // start, then a tick train that runs past the profile end, with the
    // odd abort, restart, unused kind or sender pause thrown in
    task automatic drive_random_move();
        logic [31:0] target;
        logic [14:0] limit;
        logic [31:0] actual;
        int          n;
        int          k;
        int          r;
        target = $urandom;
        r      = $urandom_range(0, 99);
        limit  = (r < 10) ? 15'd0 : (r < 20) ? 15'h7fff : 15'($urandom);
        send_beat(make_item(KIND_START, target, limit, $urandom, 15'($urandom)));
        n = 32'(joint_cfg.accel_ticks) + 32'(joint_cfg.cruise_ticks)
          + 32'(joint_cfg.decel_ticks) + $urandom_range(1, 2);
        for (k = 0; k < n; k++)
        begin
            r = $urandom_range(0, 99);
            if (r < 3)
            begin
                send_beat(make_item(KIND_ABORT, $urandom, 15'($urandom),
                                    $urandom, 15'($urandom)));
                return;
            end
            else if (r < 5)
                send_beat(make_item(2'd3, $urandom, 15'($urandom),
                                    $urandom, 15'($urandom)));
            else if (r < 7)
                send_beat(make_item(KIND_START, target, limit, $urandom, 15'($urandom)));
            else
            begin
                if (r < 9)
                    wait_until_drained();
                // a quarter of the ticks land around the target
                if ($urandom_range(0, 3) == 0)
                    actual = target + 32'($urandom_range(0, 2800)) - 32'd1400;
                else
                    actual = $urandom;
                send_beat(make_item(KIND_TICK, $urandom, 15'($urandom),
                                    actual, 15'($urandom)));
            end
        end
    endtask

    task automatic test_random_moves();
        int phase_end;
        int stop_at_count;
        int phase;
        stop_at_count = beats_sent + RANDOM_BEATS;
        phase         = 0;
        while (beats_sent < stop_at_count)
        begin
            wait_until_drained();
            load_random_profile();
            // third phase runs flat out into a long receiver hold-off
            quiet = (phase == 2);
            if (phase == 2)
                hold_req = 1'b1;
            phase_end = beats_sent + PHASE_BEATS;
            while (beats_sent < phase_end)
            begin
                if ($urandom_range(0, 9) == 0)
                    send_beat(make_item(2'($urandom), $urandom, 15'($urandom),
                                        $urandom, 15'($urandom)));
                else
                    drive_random_move();
            end
            phase++;
        end
        quiet = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // receiver: random stalls, or one long hold-off when asked
    // ------------------------------------------------------------------------
    initial
    begin : receiver
        int k;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                m_tready <= 1'b0;
                for (k = 0; k < HOLD_CYCLES; k++)
                    @(posedge clk);
                hold_req = 1'b0;
                m_tready <= 1'b1;
            end
            else
            begin
                k = pick_idle_cycles();
                if (k == 0)
                    m_tready <= 1'b1;
                else
                begin
                    m_tready <= 1'b0;
                    repeat (k - 1) @(posedge clk);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // result check: every output beat against the oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : check_results
        result_t got;
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.velocity_command = m_tdata[31:0];
            got.joint_status     = m_tdata[34:32];
            got.tick_index       = m_tdata[50:35];
            got.stop_tick        = m_tdata[66:51];
            got.stop_tick_valid  = m_tdata[67];
            got.move_done        = m_tlast;
            if (expected_results.size() == 0)
            begin
                error_count++;
                if (error_count <= REPORT_LIMIT)
                    $display("result beat with nothing expected: vel %h st %0d tick %0d",
                             got.velocity_command, got.joint_status, got.tick_index);
            end
            else
            begin
                want = expected_results.pop_front();
                if (got.velocity_command !== want.velocity_command
                    || got.joint_status !== want.joint_status
                    || got.tick_index !== want.tick_index
                    || got.stop_tick !== want.stop_tick
                    || got.stop_tick_valid !== want.stop_tick_valid
                    || got.move_done !== want.move_done)
                begin
                    error_count++;
                    if (error_count <= REPORT_LIMIT)
                        $display("mismatch at %0t: vel/st/tick/stop/valid/done exp %h %0d %0d %0d %b %b got %h %0d %0d %0d %b %b",
                                 $realtime,
                                 want.velocity_command, want.joint_status,
                                 want.tick_index, want.stop_tick,
                                 want.stop_tick_valid, want.move_done,
                                 got.velocity_command, got.joint_status,
                                 got.tick_index, got.stop_tick,
                                 got.stop_tick_valid, got.move_done);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // watchdog: too long without any beat or register access
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_profile_shape();
        test_stop_and_abort();
        test_pad_and_static();
        test_full_scale();
        test_random_moves();

        wait_until_drained();
        repeat (10) @(posedge clk);
        if (error_count == 0 && expected_results.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
